// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/elwc_pkg.sv
package elwc_pkg;

    localparam int LEN_W      = 5;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int PAT_BYTES  = 16;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 64;

    localparam logic [BYTE_W-1:0]  NEWLINE_BYTE = 8'h0A;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = 32'hFFFF_FFFF;

    // Register index = paddr[4:3]
    localparam logic [1:0] REG_WORD_LOW    = 2'd0;
    localparam logic [1:0] REG_WORD_HIGH   = 2'd1;
    localparam logic [1:0] REG_WORD_LENGTH = 2'd2;

    typedef struct packed {
        logic               clear;     // stream start: zero the window first
        logic               shift;     // shift data into the window
        logic               compare;   // compare the shifted window
        logic [BYTE_W-1:0]  data;
        logic [LEN_W-1:0]   len;       // effective word length
    } win_ctrl_t;

endpackage

// File: rtl/elwc_in_if.sv
interface elwc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_start;

    modport source (output valid, output data_byte, output stream_start, input ready);
    modport sink   (input valid, input data_byte, input stream_start, output ready);
endinterface

// File: rtl/elwc_out_if.sv
interface elwc_out_if;
    logic        valid;
    logic        ready;
    logic        match_found;
    logic [31:0] match_total;

    modport source (output valid, output match_found, output match_total, input ready);
    modport sink   (input valid, input match_found, input match_total, output ready);
endinterface

// File: rtl/elwc_window.sv
module elwc_window #(
    parameter int MAX_WORD = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  elwc_pkg::win_ctrl_t                    ctrl,
    input  logic [elwc_pkg::PAT_BYTES*8-1:0]       pattern,
    output logic                                   hit
);
    import elwc_pkg::*;

    logic [BYTE_W-1:0] win_reg  [MAX_WORD];
    logic [BYTE_W-1:0] win_next [MAX_WORD];
    logic [BYTE_W-1:0] base     [MAX_WORD];
    logic [BYTE_W-1:0] pat      [MAX_WORD];
    logic              eq;

    // Pattern bytes past the register pair read as zero.
    for (genvar g = 0; g < MAX_WORD; g++) begin : g_pat
        if (g < PAT_BYTES) begin : g_used
            assign pat[g] = pattern[8*g +: 8];
        end
        else begin : g_zero
            assign pat[g] = '0;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_WORD; i++) begin
            base[i]     = ctrl.clear ? '0 : win_reg[i];
            win_next[i] = base[i];
            if (ctrl.shift && (LEN_W'(i) == ctrl.len - LEN_W'(1))) begin
                win_next[i] = ctrl.data;
            end
        end
        // Only the first len bytes move; the rest hold.
        for (int i = 0; i < MAX_WORD - 1; i++) begin
            if (ctrl.shift && (LEN_W'(i + 1) < ctrl.len)) begin
                win_next[i] = base[i + 1];
            end
        end
        eq = 1'b1;
        for (int i = 0; i < MAX_WORD; i++) begin
            if ((LEN_W'(i) < ctrl.len) && (win_next[i] != pat[i])) begin
                eq = 1'b0;
            end
        end
        hit = ctrl.compare && eq;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < MAX_WORD; i++) begin
                win_reg[i] <= '0;
            end
        end
        else if (ctrl.shift || ctrl.clear) begin
            for (int i = 0; i < MAX_WORD; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

// File: rtl/even_line_word_counter.sv
// An input transfer's result reaches the output register in the next cycle.
// Throughput: one byte per cycle when not stalled; the window shift, byte compare
// and count update all settle between the state registers and the result register.
// Reset (rst_n, async low): window zero, even line, block load of one byte pending,
// count zero, pattern zero, word_length 1. No clearing pass is needed.
module even_line_word_counter #(
    parameter int MAX_WORD = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    elwc_in_if.sink                           item,
    elwc_out_if.source                        result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [elwc_pkg::PADDR_W-1:0]      paddr,
    input  logic [elwc_pkg::PDATA_W-1:0]      pwdata,
    output logic [elwc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import elwc_pkg::*;

    `include "assert_macros.svh"

    logic [63:0]        word_low_reg;
    logic [63:0]        word_high_reg;
    logic [LEN_W-1:0]   word_length_reg;

    logic               parity_reg,  parity_next;
    logic [LEN_W-1:0]   left_reg,    left_next;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               out_valid_reg;
    logic               found_reg;
    logic [COUNT_W-1:0] total_reg;

    logic               accept;
    logic               cfg_write;
    logic [LEN_W-1:0]   eff_len;
    logic               base_parity;
    logic [LEN_W-1:0]   base_left;
    logic [COUNT_W-1:0] base_count;
    logic               is_nl;
    logic               hit;
    win_ctrl_t          wctrl;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[4:3])
            REG_WORD_LOW:    prdata = word_low_reg;
            REG_WORD_HIGH:   prdata = word_high_reg;
            REG_WORD_LENGTH: prdata = {{(PDATA_W-LEN_W){1'b0}}, word_length_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            word_low_reg    <= '0;
            word_high_reg   <= '0;
            word_length_reg <= LEN_W'(1);
        end
        else if (cfg_write) begin
            unique case (paddr[4:3])
                REG_WORD_LOW:    word_low_reg    <= pwdata;
                REG_WORD_HIGH:   word_high_reg   <= pwdata;
                REG_WORD_LENGTH: word_length_reg <= pwdata[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (word_length_reg == '0) begin
            eff_len = LEN_W'(1);
        end
        else if (word_length_reg > LEN_W'(MAX_WORD)) begin
            eff_len = LEN_W'(MAX_WORD);
        end
        else begin
            eff_len = word_length_reg;
        end
    end

    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        base_parity = item.stream_start ? 1'b0 : parity_reg;
        base_left   = item.stream_start ? eff_len : left_reg;
        base_count  = item.stream_start ? '0 : count_reg;
        is_nl       = (item.data_byte == NEWLINE_BYTE);
        parity_next = base_parity ^ is_nl;

        wctrl.clear = accept && item.stream_start;
        wctrl.data  = item.data_byte;
        wctrl.len   = eff_len;
        if (base_left != '0) begin
            // block load: compare once on its last byte
            left_next     = base_left - LEN_W'(1);
            wctrl.shift   = accept;
            wctrl.compare = accept && (left_next == '0);
        end
        else begin
            wctrl.shift   = accept && !base_parity;
            wctrl.compare = accept && !base_parity;
            // newline ending an odd line starts a new block
            left_next     = (is_nl && base_parity) ? eff_len : '0;
        end
    end

    assign count_next = (hit && (base_count != COUNT_MAX)) ? base_count + COUNT_W'(1)
                                                           : base_count;

    elwc_window #(
        .MAX_WORD (MAX_WORD)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (wctrl),
        .pattern ({word_high_reg, word_low_reg}),
        .hit     (hit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            parity_reg    <= 1'b0;
            left_reg      <= LEN_W'(1);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (accept) begin
                parity_reg    <= parity_next;
                left_reg      <= left_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            found_reg <= hit;
            total_reg <= count_next;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.match_found = found_reg;
    assign result.match_total = total_reg;

    `ASSERT_ALWAYS(a_left_range, clk, rst_n, left_reg <= LEN_W'(MAX_WORD))
    `ASSERT_IMPLIES(a_hit_counts, clk, rst_n, out_valid_reg && found_reg, total_reg != '0)
    `ASSERT_NEXT(a_count_sat, clk, rst_n,
        accept && !item.stream_start && (count_reg == COUNT_MAX), count_reg == COUNT_MAX)
    `ASSERT_NEXT(a_odd_no_hit, clk, rst_n,
        accept && !item.stream_start && parity_reg && (left_reg == '0), !found_reg)

endmodule
